FILE: rtl/core/fba_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the frame bitmap allocator
package fba_pkg;

    localparam int FN_W           = 12;
    localparam int FC_W           = 13;
    localparam int CNT_W          = 14;
    localparam int CMD_POS_W      = 6;
    localparam int NUM_FRAMES_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;
    localparam int CMD_QDEPTH     = 2;
    localparam int RES_QDEPTH     = 2;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [FC_W-1:0] FRAME_COUNT_RST = 13'd4096;
    localparam logic            REG_FRAME_COUNT = 1'b0;

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_MARK  = 2'd2;

    localparam logic [1:0] OP_NOP   = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_MARK  = 2'd3;

    typedef struct packed {
        logic [1:0]           op;
        logic [FN_W-1:0]      word_idx;
        logic [CMD_POS_W-1:0] bit_pos;
        logic                 kernel_req;
        logic                 write_req;
    } cmd_t;

    typedef struct packed {
        logic [FN_W-1:0] granted_frame;
        logic            present;
        logic            writable;
        logic            user;
        logic            full_res;
    } res_t;

endpackage

FILE: rtl/core/fba_front.sv
`timescale 1ns / 1ps
// front end: takes request items, splits frame numbers into word and bit, classifies
module fba_front #(
    parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF,
    parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      blocked,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                func,
    input  logic [fba_pkg::FN_W-1:0]  frame_number,
    input  logic                      kernel_req,
    input  logic                      write_req,
    output logic                      cmd_wr,
    output fba_pkg::cmd_t             cmd_data,
    input  logic                      cmd_full
);

    localparam int FN_W   = fba_pkg::FN_W;
    localparam int POS_W  = $clog2(WORD_BITS);
    localparam int SH     = FN_W + POS_W;
    localparam int MAG_W  = FN_W + 2;
    localparam int PROD_W = FN_W + MAG_W;
    localparam longint MAGIC = ((64'd1 << SH) + WORD_BITS - 1) / WORD_BITS;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_SEND = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [1:0]      func_reg;
    logic [FN_W-1:0] fn_reg;
    logic            kern_reg;
    logic            wr_reg;
    logic [FN_W-1:0] q_reg, q_next;

    logic [PROD_W-1:0] prod;
    logic [FN_W-1:0]   qw;
    logic [FN_W-1:0]   rem;
    logic              in_range;
    logic              accept;

    assign full   = (state_reg != F_IDLE) || blocked;
    assign accept = push && !full;

    // reciprocal multiply gives the word index exactly for any 12-bit frame number
    assign prod   = PROD_W'(fn_reg) * PROD_W'(MAGIC);
    assign q_next = FN_W'(prod >> SH);
    assign qw     = q_reg * FN_W'(WORD_BITS);
    assign rem    = fn_reg - qw;

    assign in_range = {{(32 - FN_W){1'b0}}, fn_reg} < 32'(NUM_FRAMES);

    always_comb
    begin
        cmd_data.word_idx   = q_reg;
        cmd_data.bit_pos    = fba_pkg::CMD_POS_W'(rem);
        cmd_data.kernel_req = kern_reg;
        cmd_data.write_req  = wr_reg;
        case (func_reg)
            fba_pkg::FUNC_ALLOC: cmd_data.op = fba_pkg::OP_ALLOC;
            fba_pkg::FUNC_FREE:
                cmd_data.op = (fn_reg != '0 && in_range) ? fba_pkg::OP_FREE : fba_pkg::OP_NOP;
            fba_pkg::FUNC_MARK:
                cmd_data.op = in_range ? fba_pkg::OP_MARK : fba_pkg::OP_NOP;
            default:             cmd_data.op = fba_pkg::OP_NOP;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_wr     = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                state_next = F_SEND;
            end
            F_SEND:
            begin
                if (!cmd_full)
                begin
                    cmd_wr     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            fn_reg   <= frame_number;
            kern_reg <= kernel_req;
            wr_reg   <= write_req;
        end
        if (state_reg == F_DIV)
        begin
            q_reg <= q_next;
        end
    end

endmodule

FILE: rtl/core/fba_queue.sv
`timescale 1ns / 1ps
// short command queue between front end and bitmap engine
module fba_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  fba_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output fba_pkg::cmd_t rd_data,
    output logic          empty
);

    localparam int DEPTH = fba_pkg::CMD_QDEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fba_pkg::cmd_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign full    = cnt_reg == CNT_W'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/core/fba_back.sv
`timescale 1ns / 1ps
// bitmap engine: bitmap memory, clearing pass, allocation scan, free/mark, result queue
module fba_back #(
    parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF,
    parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [fba_pkg::FC_W-1:0]  frame_count,
    input  logic                      cmd_empty,
    input  fba_pkg::cmd_t             cmd_head,
    output logic                      cmd_pop,
    output logic                      clearing,
    input  logic                      pop,
    output logic                      empty,
    output fba_pkg::res_t             res_head
);

    localparam int FN_W  = fba_pkg::FN_W;
    localparam int CNT_W = fba_pkg::CNT_W;
    localparam int DEPTH = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W = $clog2(WORD_BITS);
    localparam int RQ    = fba_pkg::RES_QDEPTH;
    localparam int RP_W  = $clog2(RQ);
    localparam int RC_W  = $clog2(RQ + 1);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_SCAN = 2'd1;
    localparam logic [1:0] B_RMW  = 2'd2;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    logic [1:0]           state_reg, state_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]     base_reg, base_next;
    fba_pkg::cmd_t        cur_reg, cur_next;
    logic                 clr_reg, clr_next;
    logic [IDX_W-1:0]     clr_idx_reg, clr_idx_next;

    fba_pkg::res_t        res_mem [RQ];
    logic [RP_W-1:0]      rwr_ptr_reg, rrd_ptr_reg;
    logic [RC_W-1:0]      rcnt_reg, rcnt_next;

    logic                 rd_en, wr_en;
    logic [IDX_W-1:0]     rd_addr, wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 res_push, res_pop, res_space;
    fba_pkg::res_t        res_data;

    logic [CNT_W-1:0]     limit;
    logic [CNT_W-1:0]     avail;
    logic [WORD_BITS-1:0] free_vec;
    logic                 found;
    logic [POS_W-1:0]     pos;
    logic                 last_word;
    logic [CNT_W-1:0]     grant;
    logic [WORD_BITS-1:0] bit_mask;

    assign clearing  = clr_reg;
    assign empty     = rcnt_reg == '0;
    assign res_head  = res_mem[rrd_ptr_reg];
    assign res_space = rcnt_reg != RC_W'(RQ);
    assign res_pop   = pop && !empty;

    assign limit = (32'(frame_count) < 32'(NUM_FRAMES)) ? CNT_W'(frame_count)
                                                         : CNT_W'(NUM_FRAMES);
    assign avail     = limit - base_reg;
    assign last_word = (base_reg + CNT_W'(WORD_BITS)) >= limit;
    assign grant     = base_reg + CNT_W'(pos);
    assign bit_mask  = WORD_BITS'(1) << POS_W'(cur_reg.bit_pos);

    always_comb
    begin
        for (int p = 0; p < WORD_BITS; p++)
        begin
            free_vec[p] = !rdata_reg[p] && (CNT_W'(p) < avail);
        end
    end

    // lowest free bit of the word under test
    always_comb
    begin
        found = 1'b0;
        pos   = '0;
        for (int p = WORD_BITS - 1; p >= 0; p--)
        begin
            if (free_vec[p])
            begin
                found = 1'b1;
                pos   = POS_W'(p);
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        chk_idx_next = chk_idx_reg;
        base_next    = base_reg;
        cur_next     = cur_reg;
        clr_next     = clr_reg;
        clr_idx_next = clr_idx_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        res_data     = '0;

        if (clr_reg)
        begin
            wr_en        = 1'b1;
            wr_addr      = clr_idx_reg;
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == IDX_W'(DEPTH - 1))
            begin
                clr_next = 1'b0;
            end
        end

        case (state_reg)
            B_IDLE:
            begin
                if (!clr_reg && !cmd_empty && res_space)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd_head;
                    case (cmd_head.op)
                        fba_pkg::OP_ALLOC:
                        begin
                            if (limit == '0)
                            begin
                                res_push          = 1'b1;
                                res_data.full_res = 1'b1;
                            end
                            else
                            begin
                                rd_en        = 1'b1;
                                rd_addr      = '0;
                                chk_idx_next = '0;
                                base_next    = '0;
                                state_next   = B_SCAN;
                            end
                        end
                        fba_pkg::OP_FREE, fba_pkg::OP_MARK:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = IDX_W'(cmd_head.word_idx);
                            state_next = B_RMW;
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            B_SCAN:
            begin
                if (found)
                begin
                    wr_en                  = 1'b1;
                    wr_addr                = chk_idx_reg;
                    wr_data                = rdata_reg | (WORD_BITS'(1) << pos);
                    res_push               = 1'b1;
                    res_data.granted_frame = FN_W'(grant);
                    res_data.present       = 1'b1;
                    res_data.writable      = cur_reg.write_req;
                    res_data.user          = !cur_reg.kernel_req;
                    state_next             = B_IDLE;
                end
                else if (last_word)
                begin
                    res_push          = 1'b1;
                    res_data.full_res = 1'b1;
                    state_next        = B_IDLE;
                end
                else
                begin
                    rd_en        = 1'b1;
                    rd_addr      = chk_idx_reg + 1'b1;
                    chk_idx_next = chk_idx_reg + 1'b1;
                    base_next    = base_reg + CNT_W'(WORD_BITS);
                end
            end
            B_RMW:
            begin
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(cur_reg.word_idx);
                wr_data    = (cur_reg.op == fba_pkg::OP_FREE) ? (rdata_reg & ~bit_mask)
                                                               : (rdata_reg | bit_mask);
                res_push   = 1'b1;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rcnt_next = rcnt_reg;
        if (res_push && !res_pop)
        begin
            rcnt_next = rcnt_reg + 1'b1;
        end
        else if (res_pop && !res_push)
        begin
            rcnt_next = rcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
            rwr_ptr_reg <= '0;
            rrd_ptr_reg <= '0;
            rcnt_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            clr_idx_reg <= clr_idx_next;
            rcnt_reg    <= rcnt_next;
            if (res_push)
            begin
                rwr_ptr_reg <= rwr_ptr_reg + 1'b1;
            end
            if (res_pop)
            begin
                rrd_ptr_reg <= rrd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        base_reg    <= base_next;
        cur_reg     <= cur_next;
        if (res_push)
        begin
            res_mem[rwr_ptr_reg] <= res_data;
        end
    end

    // bitmap memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/frame_bitmap_allocator_unit.sv
`timescale 1ns / 1ps
// top level of the frame bitmap allocator
// Requests enter through a queue-style port (push/full) and each gives exactly one result item
// on a queue-style port (empty/pop). The front end splits the frame number into bitmap word
// and bit, holding full until the request has entered a two-entry command queue; the engine
// behind that queue handles a free or mark as a read, then a write back, and an allocate as a
// scan that walks the bitmap memory through its single read port, one word a cycle. After reset
// the bitmap is cleared one word a cycle with full held high; configuration writes are taken
// during that time. frame_count sits at address 0 of the APB-style port and should only be
// written while no request is in flight.
module frame_bitmap_allocator_unit #(
    parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF,
    parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fba_pkg::PADDR_W-1:0]  paddr,
    input  logic [fba_pkg::PDATA_W-1:0]  pwdata,
    output logic [fba_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   func,
    input  logic [fba_pkg::FN_W-1:0]     frame_number,
    input  logic                         kernel_req,
    input  logic                         write_req,
    output logic                         empty,
    input  logic                         pop,
    output logic [fba_pkg::FN_W-1:0]     granted_frame,
    output logic                         present,
    output logic                         writable,
    output logic                         user,
    output logic                         full_res
);

    localparam int FC_W = fba_pkg::FC_W;

    logic [FC_W-1:0]  frame_count_reg;
    logic             cfg_wr;
    logic             clearing;
    logic             cmd_wr, cmd_full, cmd_pop, cmd_empty;
    fba_pkg::cmd_t    cmd_in, cmd_head;
    fba_pkg::res_t    res_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == fba_pkg::REG_FRAME_COUNT)
        begin
            prdata = fba_pkg::PDATA_W'(frame_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= fba_pkg::FRAME_COUNT_RST;
        end
        else if (cfg_wr && paddr[2] == fba_pkg::REG_FRAME_COUNT)
        begin
            frame_count_reg <= pwdata[FC_W-1:0];
        end
    end

    fba_front #(
        .NUM_FRAMES (NUM_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .blocked      (clearing),
        .push         (push),
        .full         (full),
        .func         (func),
        .frame_number (frame_number),
        .kernel_req   (kernel_req),
        .write_req    (write_req),
        .cmd_wr       (cmd_wr),
        .cmd_data     (cmd_in),
        .cmd_full     (cmd_full)
    );

    fba_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_wr),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .empty   (cmd_empty)
    );

    fba_back #(
        .NUM_FRAMES (NUM_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_count (frame_count_reg),
        .cmd_empty   (cmd_empty),
        .cmd_head    (cmd_head),
        .cmd_pop     (cmd_pop),
        .clearing    (clearing),
        .pop         (pop),
        .empty       (empty),
        .res_head    (res_head)
    );

    assign granted_frame = res_head.granted_frame;
    assign present       = res_head.present;
    assign writable      = res_head.writable;
    assign user          = res_head.user;
    assign full_res      = res_head.full_res;

endmodule

FILE: rtl/core/fba_checker.sv
`timescale 1ns / 1ps
// port-level checker of the frame bitmap allocator and its bind
module fba_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fba_pkg::PADDR_W-1:0]  paddr,
    input  logic [fba_pkg::PDATA_W-1:0]  pwdata,
    input  logic [fba_pkg::PDATA_W-1:0]  prdata,
    input  logic                         pready,
    input  logic                         empty,
    input  logic                         pop,
    input  logic [fba_pkg::FN_W-1:0]     granted_frame,
    input  logic                         present,
    input  logic                         writable,
    input  logic                         user,
    input  logic                         full_res
);

    // a grant and a full report never share one item
    a_grant_or_full: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(present && full_res))
        else $error("result item both granted and full");

    // items without a grant carry no frame and no writable or user flag
    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !present) |-> (granted_frame == '0 && !writable && !user))
        else $error("non-grant item carries frame or flags");

    // a waiting item holds until taken
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(granted_frame) && $stable(present)
                              && $stable(writable) && $stable(user) && $stable(full_res)))
        else $error("waiting result item changed");

    // frame_count reads back what was just written
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[2] == fba_pkg::REG_FRAME_COUNT)
        |=> (paddr[2] != fba_pkg::REG_FRAME_COUNT
             || prdata[fba_pkg::FC_W-1:0] == $past(pwdata[fba_pkg::FC_W-1:0])))
        else $error("frame_count readback mismatch");

endmodule

bind frame_bitmap_allocator_unit fba_checker u_fba_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the frame bitmap allocator: directed rows, then random phases
module tb_top;

    localparam int FN_W           = fba_pkg::FN_W;
    localparam int FC_W           = fba_pkg::FC_W;
    localparam int PADDR_W        = fba_pkg::PADDR_W;
    localparam int PDATA_W        = fba_pkg::PDATA_W;
    localparam int NUM_FRAMES_DEF = fba_pkg::NUM_FRAMES_DEF;
    localparam logic [FC_W-1:0] FRAME_COUNT_RST = fba_pkg::FRAME_COUNT_RST;
    localparam logic REG_FRAME_COUNT = fba_pkg::REG_FRAME_COUNT;
    localparam logic [1:0] FUNC_ALLOC = fba_pkg::FUNC_ALLOC;
    localparam logic [1:0] FUNC_FREE  = fba_pkg::FUNC_FREE;
    localparam logic [1:0] FUNC_MARK  = fba_pkg::FUNC_MARK;

    typedef fba_pkg::res_t res_t;

    localparam logic [1:0]         FUNC_UNUSED      = 2'd3;
    localparam logic [PADDR_W-1:0] FRAME_COUNT_ADDR = PADDR_W'(4 * REG_FRAME_COUNT);
    localparam int IDLE_PCT      = 22;
    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int NUM_PHASES    = 9;
    localparam int PHASE_ITEMS   = 216;
    localparam int HOLD_PHASE    = 1;
    localparam int STEADY_PHASE  = 4;
    localparam int unsigned CYCLE_LIMIT = 2000000;

    localparam res_t NO_RESULT   = '0;
    localparam res_t FULL_RESULT = {12'd0, 1'b0, 1'b0, 1'b0, 1'b1};

    typedef struct packed {
        logic            is_cfg;
        logic [FC_W-1:0] cfg_value;
        logic [1:0]      op;
        logic [FN_W-1:0] frame;
        logic            kern;
        logic            wr;
        logic            has_want;
        res_t            want;
    } opening_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                push;
    logic                full;
    logic [1:0]          func;
    logic [FN_W-1:0]     frame_number;
    logic                kernel_req;
    logic                write_req;
    logic                empty;
    logic                pop;
    logic [FN_W-1:0]     granted_frame;
    logic                present;
    logic                writable;
    logic                user;
    logic                full_res;

    logic [NUM_FRAMES_DEF-1:0] frame_used;
    logic [FC_W-1:0]           frames_managed;
    res_t                      pending_grants[$];
    res_t                      want_res;

    bit          steady;
    bit          hold_request;
    int unsigned mismatch_count;
    int unsigned accepted_count;
    int unsigned granted_count;
    int unsigned refused_count;
    int unsigned settings_count;
    int unsigned cycle_count;

    int unsigned phase_frame_count [NUM_PHASES] = '{32, 45, 0, 100, 4096, 33, 8191, 64, 4095};

    opening_row_t opening_rows [22] = '{
        {1'b0, 13'd0,    FUNC_ALLOC,  12'd0,     1'b0, 1'b1, 1'b1, {12'd0, 1'b1, 1'b1, 1'b1, 1'b0}},
        {1'b0, 13'd0,    FUNC_ALLOC,  12'd0,     1'b1, 1'b0, 1'b1, {12'd1, 1'b1, 1'b0, 1'b0, 1'b0}},
        {1'b0, 13'd0,    FUNC_FREE,   12'd0,     1'b0, 1'b0, 1'b1, NO_RESULT},
        {1'b0, 13'd0,    FUNC_ALLOC,  12'd0,     1'b1, 1'b1, 1'b1, {12'd2, 1'b1, 1'b1, 1'b0, 1'b0}},
        {1'b0, 13'd0,    FUNC_FREE,   12'd1,     1'b0, 1'b0, 1'b1, NO_RESULT},
        {1'b0, 13'd0,    FUNC_ALLOC,  12'd0,     1'b0, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 13'd0,    FUNC_MARK,   12'd4095,  1'b0, 1'b0, 1'b1, NO_RESULT},
        {1'b0, 13'd0,    FUNC_MARK,   12'd3,     1'b0, 1'b0, 1'b1, NO_RESULT},
        {1'b0, 13'd0,    FUNC_ALLOC,  12'd0,     1'b1, 1'b1, 1'b0, NO_RESULT},
        {1'b0, 13'd0,    FUNC_UNUSED, 12'd4095,  1'b1, 1'b1, 1'b1, NO_RESULT},
        {1'b0, 13'd0,    FUNC_FREE,   12'd4095,  1'b0, 1'b0, 1'b1, NO_RESULT},
        {1'b0, 13'd0,    FUNC_MARK,   12'hAAA,   1'b1, 1'b0, 1'b1, NO_RESULT},
        {1'b0, 13'd0,    FUNC_FREE,   12'h555,   1'b0, 1'b1, 1'b1, NO_RESULT},
        {1'b1, 13'd0,    FUNC_ALLOC,  12'd0,     1'b0, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 13'd0,    FUNC_ALLOC,  12'd0,     1'b0, 1'b1, 1'b1, FULL_RESULT},
        {1'b0, 13'd0,    FUNC_FREE,   12'd2,     1'b0, 1'b0, 1'b1, NO_RESULT},
        {1'b0, 13'd0,    FUNC_ALLOC,  12'd0,     1'b1, 1'b1, 1'b1, FULL_RESULT},
        {1'b1, 13'd8191, FUNC_ALLOC,  12'd0,     1'b0, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 13'd0,    FUNC_ALLOC,  12'd0,     1'b0, 1'b1, 1'b0, NO_RESULT},
        {1'b1, 13'd32,   FUNC_ALLOC,  12'd0,     1'b0, 1'b0, 1'b0, NO_RESULT},
        {1'b0, 13'd0,    FUNC_MARK,   12'd31,    1'b0, 1'b0, 1'b1, NO_RESULT},
        {1'b0, 13'd0,    FUNC_ALLOC,  12'd0,     1'b1, 1'b0, 1'b0, NO_RESULT}
    };

    frame_bitmap_allocator_unit dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < 50)
            $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [FN_W-1:0] got,
                                 input logic [FN_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic res_t predict_grant(input logic [1:0] op, input logic [FN_W-1:0] frame,
                                           input logic kern, input logic wr);
        res_t r;
        int   search_end;
        int   f;
        r = '0;
        search_end = (frames_managed < NUM_FRAMES_DEF) ? int'(frames_managed) : NUM_FRAMES_DEF;
        case (op)
            FUNC_ALLOC:
            begin
                f = 0;
                while (f < search_end && frame_used[f])
                    f++;
                if (f < search_end)
                begin
                    frame_used[f]   = 1'b1;
                    r.granted_frame = FN_W'(f);
                    r.present       = 1'b1;
                    r.writable      = wr;
                    r.user          = ~kern;
                end
                else
                    r.full_res = 1'b1;
            end
            FUNC_FREE:
            begin
                if (frame != '0)
                    frame_used[frame] = 1'b0;
            end
            FUNC_MARK:
                frame_used[frame] = 1'b1;
            default:
                r = '0;
        endcase
        return r;
    endfunction

    task automatic offer_request(input logic [1:0] op, input logic [FN_W-1:0] frame,
                                 input logic kern, input logic wr,
                                 input logic has_want, input res_t want);
        res_t predicted;
        bit   taken;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            if (!steady && $urandom_range(99) < IDLE_PCT)
                push <= 1'b0;
            else
            begin
                push         <= 1'b1;
                func         <= op;
                frame_number <= frame;
                kernel_req   <= kern;
                write_req    <= wr;
            end
            @(posedge clk);
            if (push && !full)
            begin
                taken = 1'b1;
                predicted = predict_grant(op, frame, kern, wr);
                pending_grants.push_back(has_want ? want : predicted);
                accepted_count++;
            end
        end
    endtask

    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_frame_count();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= FRAME_COUNT_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== PDATA_W'(frames_managed))
            report_mismatch($sformatf("frame_count read %0d expected %0d", prdata, frames_managed));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_frame_count(input logic [FC_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FRAME_COUNT_ADDR;
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        frames_managed = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_frame_count();
        settings_count++;
    endtask

    // result side: random pop, always on in the steady phase, with one long hold-off on request
    initial
    begin : result_drain
        int hold_left;
        hold_left = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_grants.size() == 0)
                report_mismatch("result with no request waiting");
            else
            begin
                want_res = pending_grants.pop_front();
                compare_field("granted_frame", granted_frame, want_res.granted_frame);
                compare_field("present", present, want_res.present);
                compare_field("writable", writable, want_res.writable);
                compare_field("user", user, want_res.user);
                compare_field("full_res", full_res, want_res.full_res);
                granted_count += want_res.present;
                refused_count += want_res.full_res;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("frame_bitmap_allocator_unit test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [1:0]      pick_op;
        logic [FN_W-1:0] pick_frame;
        int              roll;
        int              search_end;
        int              span;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        push           = 1'b0;
        func           = FUNC_ALLOC;
        frame_number   = '0;
        kernel_req     = 1'b0;
        write_req      = 1'b0;
        steady         = 1'b0;
        hold_request   = 1'b0;
        frame_used     = '0;
        frames_managed = FRAME_COUNT_RST;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        check_frame_count();

        foreach (opening_rows[r])
        begin
            if (opening_rows[r].is_cfg)
            begin
                settle();
                write_frame_count(opening_rows[r].cfg_value);
            end
            else
                offer_request(opening_rows[r].op, opening_rows[r].frame, opening_rows[r].kern,
                              opening_rows[r].wr, opening_rows[r].has_want, opening_rows[r].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            write_frame_count(FC_W'(phase_frame_count[p]));
            steady = (p == STEADY_PHASE);
            if (p == HOLD_PHASE)
                hold_request = 1'b1;
            search_end = (phase_frame_count[p] < NUM_FRAMES_DEF) ?
                         int'(phase_frame_count[p]) : NUM_FRAMES_DEF;
            span = (search_end > 160) ? 160 : search_end + 1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 48)
                    pick_op = FUNC_ALLOC;
                else if (roll < 73)
                    pick_op = FUNC_FREE;
                else if (roll < 93)
                    pick_op = FUNC_MARK;
                else
                    pick_op = FUNC_UNUSED;
                if ($urandom_range(99) < 60)
                    pick_frame = FN_W'($urandom_range(span));
                else
                    pick_frame = FN_W'($urandom);
                offer_request(pick_op, pick_frame, 1'($urandom), 1'($urandom), 1'b0, NO_RESULT);
            end
            steady = 1'b0;
        end

        settle();
        $display("covered %0d requests over %0d frame_count settings (0 through 8191)",
                 accepted_count, settings_count);
        $display("%0d frames granted, %0d allocations refused with no free frame",
                 granted_count, refused_count);
        if (mismatch_count == 0)
            $display("frame_bitmap_allocator_unit test passed");
        else
            $display("frame_bitmap_allocator_unit test failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/fba_pkg.sv
rtl/core/fba_front.sv
rtl/core/fba_queue.sv
rtl/core/fba_back.sv
rtl/core/frame_bitmap_allocator_unit.sv
rtl/core/fba_checker.sv
test/tb_top.sv
